@@ hdl/gmcp_pkg.sv @@
// Shared constants for the grid minimum-cost-path block.
`default_nettype none

package gmcp_pkg;

   // Widths of the streamed fields.
   localparam int unsigned COST_W = 16;
   localparam int unsigned PATH_W = 32;

   // Saturated path cost, which also stands for an off-grid neighbor.
   localparam logic [PATH_W-1:0] PATH_INF = {PATH_W{1'b1}};

   // Register file layout.
   localparam int unsigned ROW_COUNT_W = 13;
   localparam int unsigned COL_COUNT_W = 11;
   localparam int unsigned CSR_DATA_W  = 13;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'b1;

   // Row limits and position width.
   localparam int unsigned MAX_ROWS  = 4096;
   localparam int unsigned ROW_POS_W = 12;

   // Default depth of the line buffer.
   localparam int unsigned MAX_COLS_DEFAULT = 1024;

endpackage

`default_nettype wire

@@ hdl/grid_min_cost_path.sv @@
// Streaming minimum-cost-path engine over a grid with a one-row line buffer.
//
// Usage: cell costs enter on the req_ channel in reverse raster order (last row
// first, last column of each row first). Every accepted word yields one rsp_
// word carrying the cost-to-go of that cell; the top-left cell's word has
// rsp_is_answer set and holds the grid total, after which the block starts on
// the next grid. Grid size is set through csr_ (row count at index 0, column
// count at index 1) while the block is idle; zero counts act as one.
// Accepted words are registered in the compute stage, then the output register.
// Throughput is one word per cycle while rsp_stall is low: a cell's line-buffer
// read is issued at acceptance and its one add plus three-way minimum runs in
// the next cycle, forwarding a just-written entry that one-column grids reread.
// When the receiver stalls, the finished word waits in the output register and
// one more word may be taken into the compute stage; req_stall rises only
// when both are occupied.
// Reset clears the grid position and all valid flags; the line buffer needs no
// clearing since each entry is written in a row before the next row reads it.
`default_nettype none

module grid_min_cost_path #(
   parameter int unsigned MAX_COLS = gmcp_pkg::MAX_COLS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Configuration write port.
   input  wire logic                            csr_wen,
   input  wire logic [gmcp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gmcp_pkg::CSR_DATA_W-1:0] csr_wdata,
   // Cell cost channel.
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [gmcp_pkg::COST_W-1:0]     req_cell_cost,
   // Path cost channel.
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [gmcp_pkg::PATH_W-1:0]          rsp_path_cost,
   output logic                                 rsp_is_answer
);

   localparam int unsigned AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int unsigned CNT_W = ((AW > gmcp_pkg::COL_COUNT_W) ? AW
                                    : gmcp_pkg::COL_COUNT_W) + 1;
   localparam int unsigned RW    = gmcp_pkg::ROW_COUNT_W;
   localparam int unsigned PW    = gmcp_pkg::PATH_W;
   localparam int unsigned CW    = gmcp_pkg::COST_W;

   // Configuration registers.
   logic [RW-1:0]                      row_count_ff;
   logic [gmcp_pkg::COL_COUNT_W-1:0]   col_count_ff;

   // Grid position of the next word to be accepted.
   logic [gmcp_pkg::ROW_POS_W-1:0]     row_pos_ff;
   logic [AW-1:0]                      col_pos_ff;

   // Compute stage.
   logic                               s1_valid_ff;
   logic [CW-1:0]                      s1_cost_ff;
   logic [AW-1:0]                      s1_slot_ff;
   logic                               s1_row0_ff;
   logic                               s1_col0_ff;
   logic                               s1_answer_ff;
   logic [PW-1:0]                      rd_data_ff;
   logic                               fwd_hit_ff;
   logic [PW-1:0]                      fwd_data_ff;

   // Neighbor values from the previous cell.
   logic [PW-1:0]                      right_ff;
   logic [PW-1:0]                      diag_ff;

   // Output register.
   logic                               rsp_valid_ff;
   logic [PW-1:0]                      rsp_path_cost_ff;
   logic                               rsp_is_answer_ff;

   // Line buffer holding the row below, indexed by column from the right.
   logic [PW-1:0]                      line_mem [MAX_COLS];

   logic                               accept;
   logic                               s1_go;
   logic [RW-1:0]                      rows_eff;
   logic [CNT_W-1:0]                   cols_ext;
   logic [CNT_W-1:0]                   cols_eff;
   logic                               last_col;
   logic                               last_row;
   logic [PW-1:0]                      below_raw;
   logic [PW-1:0]                      below_in;
   logic [PW-1:0]                      right_in;
   logic [PW-1:0]                      diag_in;
   logic [PW-1:0]                      min_rd;
   logic [PW-1:0]                      min_all;
   logic [PW:0]                        sum;
   logic [PW-1:0]                      result_in;

   // Handshake: the compute stage moves on when the output register frees up.
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !(!rsp_valid_ff || !rsp_stall);
   assign accept    = req_valid && !req_stall;

   // Effective counts with zero and oversized values clamped.
   always_comb begin
      if (row_count_ff == '0) begin
         rows_eff = RW'(1);
      end else if (row_count_ff > RW'(gmcp_pkg::MAX_ROWS)) begin
         rows_eff = RW'(gmcp_pkg::MAX_ROWS);
      end else begin
         rows_eff = row_count_ff;
      end
      cols_ext = CNT_W'(col_count_ff);
      if (cols_ext == '0) begin
         cols_eff = CNT_W'(1);
      end else if (cols_ext > CNT_W'(MAX_COLS)) begin
         cols_eff = CNT_W'(MAX_COLS);
      end else begin
         cols_eff = cols_ext;
      end
   end

   assign last_col = (CNT_W'(col_pos_ff) + CNT_W'(1)) >= cols_eff;
   assign last_row = (RW'(row_pos_ff) + RW'(1)) >= rows_eff;

   // Neighbor selection, three-way minimum and saturating add.
   always_comb begin
      below_raw = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
      below_in  = s1_row0_ff ? gmcp_pkg::PATH_INF : below_raw;
      right_in  = s1_col0_ff ? gmcp_pkg::PATH_INF : right_ff;
      diag_in   = (s1_row0_ff || s1_col0_ff) ? gmcp_pkg::PATH_INF : diag_ff;
      min_rd    = (right_in < diag_in) ? right_in : diag_in;
      min_all   = (below_in < min_rd) ? below_in : min_rd;
      sum       = {1'b0, min_all} + (PW+1)'(s1_cost_ff);
      if (s1_row0_ff && s1_col0_ff) begin
         result_in = PW'(s1_cost_ff);
      end else if (sum[PW]) begin
         result_in = gmcp_pkg::PATH_INF;
      end else begin
         result_in = sum[PW-1:0];
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= RW'(1);
         col_count_ff <= gmcp_pkg::COL_COUNT_W'(1);
      end else if (csr_wen) begin
         case (csr_index)
            gmcp_pkg::CSR_ROW_COUNT: row_count_ff <= csr_wdata[RW-1:0];
            gmcp_pkg::CSR_COL_COUNT: col_count_ff <= csr_wdata[gmcp_pkg::COL_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Position counters advance on every accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff <= '0;
         col_pos_ff <= '0;
      end else if (accept) begin
         if (last_col) begin
            col_pos_ff <= '0;
            row_pos_ff <= last_row ? '0 : row_pos_ff + 1'b1;
         end else begin
            col_pos_ff <= col_pos_ff + 1'b1;
         end
      end
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Accepted word enters the compute stage; the line buffer read is issued.
   // A write to the same entry at this very edge is caught for forwarding.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cost_ff   <= req_cell_cost;
         s1_slot_ff   <= col_pos_ff;
         s1_row0_ff   <= (row_pos_ff == '0);
         s1_col0_ff   <= (col_pos_ff == '0);
         s1_answer_ff <= last_col && last_row;
         rd_data_ff   <= line_mem[col_pos_ff];
         fwd_hit_ff   <= s1_go && (s1_slot_ff == col_pos_ff);
         fwd_data_ff  <= result_in;
      end
   end

   // Write-back of the computed cell into the line buffer.
   always_ff @(posedge clock) begin
      if (s1_go) begin
         line_mem[s1_slot_ff] <= result_in;
      end
   end

   // Neighbor registers follow each computed cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         right_ff <= gmcp_pkg::PATH_INF;
         diag_ff  <= gmcp_pkg::PATH_INF;
      end else if (s1_go) begin
         right_ff <= result_in;
         diag_ff  <= below_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_path_cost_ff <= result_in;
         rsp_is_answer_ff <= s1_answer_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_path_cost = rsp_path_cost_ff;
   assign rsp_is_answer = rsp_is_answer_ff;

endmodule

`default_nettype wire

@@ hdl/gmcp_checker.sv @@
// Port-level checks for the grid minimum-cost-path block, bound to its top level.
`default_nettype none

module gmcp_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [gmcp_pkg::PATH_W-1:0]    rsp_path_cost,
   input wire logic                           rsp_is_answer
);

   // The block comes out of reset with nothing to deliver.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // Input back-pressure only arises from a stalled, full output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result word");

   // After reset the input side is free to take a word.
   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_stall)
      else $error("req_stall high right after reset");

   // A stalled result word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_path_cost)
                                 && $stable(rsp_is_answer))
      else $error("stalled result word changed");

endmodule

bind grid_min_cost_path gmcp_checker u_gmcp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_path_cost (rsp_path_cost),
   .rsp_is_answer (rsp_is_answer)
);

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the streaming grid minimum-cost-path block.
`default_nettype none

module testbench;

   localparam int unsigned LINE_DEPTH   = gmcp_pkg::MAX_COLS_DEFAULT;
   localparam int unsigned LONG_HOLD    = 80;
   localparam int unsigned RANDOM_WORDS = 770;

   // One expected result word.
   typedef struct packed {
      logic [gmcp_pkg::PATH_W-1:0] path_cost;
      logic                        is_answer;
   } path_word_type;

   // Block ports; the inputs are driven to known values from time zero.
   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_wen = 1'b0;
   logic [gmcp_pkg::CSR_IDX_W-1:0]     csr_index = gmcp_pkg::CSR_ROW_COUNT;
   logic [gmcp_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [gmcp_pkg::COST_W-1:0]        req_cell_cost = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [gmcp_pkg::PATH_W-1:0]        rsp_path_cost;
   logic                               rsp_is_answer;

   // Shadow of the configuration and of the cost-to-go state.
   logic [gmcp_pkg::ROW_COUNT_W-1:0]   row_count_reg = gmcp_pkg::ROW_COUNT_W'(1);
   logic [gmcp_pkg::COL_COUNT_W-1:0]   col_count_reg = gmcp_pkg::COL_COUNT_W'(1);
   logic [gmcp_pkg::PATH_W-1:0]        below_costs [LINE_DEPTH];
   logic [gmcp_pkg::PATH_W-1:0]        right_cost = gmcp_pkg::PATH_INF;
   logic [gmcp_pkg::PATH_W-1:0]        diag_cost = gmcp_pkg::PATH_INF;
   int unsigned                        cur_row = 0;
   int unsigned                        cur_col = 0;
   bit                                 grid_done = 1'b0;

   // Expected words in order, plus run bookkeeping.
   path_word_type                      pending_paths [$];
   int unsigned                        error_count = 0;
   int unsigned                        results_seen = 0;
   int unsigned                        hold_requests = 0;
   int unsigned                        holds_served = 0;
   int unsigned                        hold_left = 0;
   bit                                 send_gaps = 1'b1;
   bit                                 recv_gaps = 1'b1;

   always #5 clock = ~clock;

   grid_min_cost_path #(.MAX_COLS(LINE_DEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cell_cost (req_cell_cost),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_path_cost (rsp_path_cost),
      .rsp_is_answer (rsp_is_answer)
   );

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string what,
                                  input logic [gmcp_pkg::PATH_W-1:0] got,
                                  input logic [gmcp_pkg::PATH_W-1:0] want);
      error_count++;
      $display("mismatch at word %0d: %s got %0h expected %0h",
               results_seen, what, got, want);
   endtask

   // Compute the cost-to-go of one accepted cell and queue the expected word.
   task automatic predict_cost_to_go(input logic [gmcp_pkg::COST_W-1:0] cost);
      int unsigned                   rows;
      int unsigned                   cols;
      int unsigned                   slot;
      logic [gmcp_pkg::PATH_W-1:0]   below;
      logic [gmcp_pkg::PATH_W-1:0]   right;
      logic [gmcp_pkg::PATH_W-1:0]   diag;
      logic [gmcp_pkg::PATH_W-1:0]   best;
      logic [gmcp_pkg::PATH_W-1:0]   result;
      logic [gmcp_pkg::PATH_W:0]     total;
      bit                            last_col;
      bit                            last_row;
      path_word_type                 word;

      // Zero counts act as one, oversized counts act as the maximum.
      rows = row_count_reg;
      if (rows == 0) rows = 1;
      else if (rows > gmcp_pkg::MAX_ROWS) rows = gmcp_pkg::MAX_ROWS;
      cols = col_count_reg;
      if (cols == 0) cols = 1;
      else if (cols > LINE_DEPTH) cols = LINE_DEPTH;

      // Off-grid neighbors are infinite.
      slot  = cur_col % LINE_DEPTH;
      below = (cur_row == 0) ? gmcp_pkg::PATH_INF : below_costs[slot];
      right = (cur_col == 0) ? gmcp_pkg::PATH_INF : right_cost;
      diag  = (cur_row == 0 || cur_col == 0) ? gmcp_pkg::PATH_INF : diag_cost;
      best  = (below < right) ? below : right;
      if (diag < best) best = diag;

      // The bottom-right cell takes its own cost; all other sums saturate.
      if (cur_row == 0 && cur_col == 0) begin
         result = gmcp_pkg::PATH_W'(cost);
      end else begin
         total  = {1'b0, best} + (gmcp_pkg::PATH_W+1)'(cost);
         result = total[gmcp_pkg::PATH_W] ? gmcp_pkg::PATH_INF
                                          : total[gmcp_pkg::PATH_W-1:0];
      end

      diag_cost         = below;
      right_cost        = result;
      below_costs[slot] = result;

      // A row or grid ends once the position reaches or passes the counts.
      last_col       = (cur_col + 1 >= cols);
      last_row       = (cur_row + 1 >= rows);
      grid_done      = last_col && last_row;
      word.path_cost = result;
      word.is_answer = grid_done;
      pending_paths.push_back(word);

      if (last_col) begin
         cur_col    = 0;
         right_cost = gmcp_pkg::PATH_INF;
         diag_cost  = gmcp_pkg::PATH_INF;
         cur_row    = last_row ? 0 : cur_row + 1;
      end else begin
         cur_col++;
      end
   endtask

   // Cell costs lean towards zero and all ones, the rest spread over the field.
   function automatic logic [gmcp_pkg::COST_W-1:0] pick_cost();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return gmcp_pkg::COST_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Offer one cell word, with random idle cycles ahead of it, and hold it until taken.
   task automatic send_cell(input logic [gmcp_pkg::COST_W-1:0] cost);
      while (send_gaps && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cell_cost <= cost;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_cost_to_go(cost);
   endtask

   task automatic send_cells(input int unsigned count);
      repeat (count) send_cell(pick_cost());
   endtask

   // Send random cells until the top-left cell of the grid has gone in.
   task automatic send_grid();
      do send_cell(pick_cost()); while (!grid_done);
   endtask

   // Write one count register; the idle wait after it keeps write enable pulses apart.
   task automatic write_count(input logic [gmcp_pkg::CSR_IDX_W-1:0] idx,
                              input logic [gmcp_pkg::CSR_DATA_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == gmcp_pkg::CSR_ROW_COUNT) begin
         row_count_reg = value[gmcp_pkg::ROW_COUNT_W-1:0];
      end else begin
         col_count_reg = value[gmcp_pkg::COL_COUNT_W-1:0];
      end
      @(posedge clock);
   endtask

   // Stop offering words and wait until every expected word has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_paths.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Check each accepted result word against the expected order.
   always @(posedge clock) begin : rsp_side
      path_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_paths.size() == 0) begin
            report_mismatch("unexpected word, path_cost", rsp_path_cost, '0);
         end else begin
            want = pending_paths.pop_front();
            if (rsp_path_cost !== want.path_cost)
               report_mismatch("path_cost", rsp_path_cost, want.path_cost);
            if (rsp_is_answer !== want.is_answer)
               report_mismatch("is_answer", gmcp_pkg::PATH_W'(rsp_is_answer),
                               gmcp_pkg::PATH_W'(want.is_answer));
         end
      end
   end

   // Receiver stall: random idling, or a long hold counted down cycle by cycle.
   always @(posedge clock) begin : rsp_stall_driver
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_stall    <= 1'b1;
         hold_left    <= LONG_HOLD - 1;
         holds_served <= holds_served + 1;
      end else begin
         rsp_stall <= recv_gaps && ($urandom_range(0, 99) < 17);
      end
   end

   // After reset the grid is one cell, so every word is its own answer.
   task automatic test_reset_defaults();
      send_cell('0);
      send_cell('1);
      send_cell(16'h0001);
      send_cell(16'h8000);
      wait_idle();
   endtask

   // A small grid with hand-picked costs, extremes included.
   task automatic test_small_grid();
      logic [gmcp_pkg::COST_W-1:0] costs [12];
      costs = '{16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF,
                16'hFFFF, 16'h0000, 16'h8000, 16'h0002,
                16'h1234, 16'hFFFF, 16'h0000, 16'hFFFE};
      write_count(gmcp_pkg::CSR_ROW_COUNT, 13'd3);
      write_count(gmcp_pkg::CSR_COL_COUNT, 13'd4);
      foreach (costs[i]) send_cell(costs[i]);
      wait_idle();
   endtask

   // Zero counts behave as a one-cell grid.
   task automatic test_zero_counts();
      write_count(gmcp_pkg::CSR_ROW_COUNT, 13'd0);
      write_count(gmcp_pkg::CSR_COL_COUNT, 13'd0);
      send_cells(2);
      wait_idle();
   endtask

   // Narrow the grid while a grid is under way; the position must be kept.
   task automatic test_mid_grid_resize();
      write_count(gmcp_pkg::CSR_ROW_COUNT, 13'd4);
      write_count(gmcp_pkg::CSR_COL_COUNT, 13'd6);
      send_cells(9);
      wait_idle();
      // Column count now equals the next position: this cell ends the row.
      write_count(gmcp_pkg::CSR_COL_COUNT, 13'd4);
      send_cells(4);
      wait_idle();
      // Column count now below the position: the row ends at once.
      write_count(gmcp_pkg::CSR_COL_COUNT, 13'd2);
      send_cells(1);
      wait_idle();
      // Row count below the rows already done: this row is the last.
      write_count(gmcp_pkg::CSR_ROW_COUNT, 13'd2);
      send_cells(2);
      wait_idle();
   endtask

   // Largest sizes: oversized rows on a single column, then oversized columns.
   task automatic test_large_grids();
      write_count(gmcp_pkg::CSR_COL_COUNT, 13'd1);
      write_count(gmcp_pkg::CSR_ROW_COUNT, 13'h1FFF);
      send_cells(40);
      wait_idle();
      // Dropping the row count below the rows done makes the next cell the answer.
      write_count(gmcp_pkg::CSR_ROW_COUNT, 13'd1);
      send_grid();
      wait_idle();
      // The column count clamps to the line buffer depth.
      write_count(gmcp_pkg::CSR_COL_COUNT, 13'h1FFF);
      send_grid();
      wait_idle();
   endtask

   // Hold the receiver off while words keep coming, so the input side stalls.
   task automatic test_backpressure();
      write_count(gmcp_pkg::CSR_ROW_COUNT, 13'd3);
      write_count(gmcp_pkg::CSR_COL_COUNT, 13'd10);
      send_gaps = 1'b0;
      hold_requests++;
      send_cells(30);
      send_gaps = 1'b1;
      wait_idle();
   endtask

   // Random grid sizes, whole grids at a time, with one stretch free of idling.
   task automatic test_random_grids();
      int unsigned start_results;
      int unsigned phase;
      int unsigned rows;
      int unsigned cols;
      start_results = results_seen;
      phase = 0;
      while (results_seen - start_results < RANDOM_WORDS) begin
         send_gaps = !(phase >= 6 && phase < 12);
         recv_gaps = send_gaps;
         if ($urandom_range(0, 9) == 0) begin
            rows = $urandom_range(1, 2);
            cols = $urandom_range(30, 90);
         end else begin
            rows = $urandom_range(1, 8);
            cols = $urandom_range(1, 12);
         end
         if ($urandom_range(0, 15) == 0) rows = 0;
         if ($urandom_range(0, 15) == 0) cols = 0;
         case ($urandom_range(0, 3))
            0: write_count(gmcp_pkg::CSR_ROW_COUNT, gmcp_pkg::CSR_DATA_W'(rows));
            1: write_count(gmcp_pkg::CSR_COL_COUNT, gmcp_pkg::CSR_DATA_W'(cols));
            default: begin
               write_count(gmcp_pkg::CSR_ROW_COUNT, gmcp_pkg::CSR_DATA_W'(rows));
               write_count(gmcp_pkg::CSR_COL_COUNT, gmcp_pkg::CSR_DATA_W'(cols));
            end
         endcase
         repeat ($urandom_range(1, 2)) send_grid();
         wait_idle();
         phase++;
      end
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
   endtask

   // Main sequence.
   initial begin
      foreach (below_costs[i]) below_costs[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_small_grid();
      test_zero_counts();
      test_mid_grid_resize();
      test_backpressure();
      test_large_grids();
      test_random_grids();
      wait_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
